@@ src/piece_span_to_file_segments_top_macros.svh @@
// ------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the span mapper checks.
// ------------------------------------------------------------------------
`ifndef PIECE_SPAN_TO_FILE_SEGMENTS_TOP_MACROS_SVH
`define PIECE_SPAN_TO_FILE_SEGMENTS_TOP_MACROS_SVH

// Implication checked on every clock out of reset.
`define PSTFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold out of reset.
`define PSTFS_NEVER(label, cond, msg) \
  `PSTFS_ASSERT(label, !(cond), msg)

`endif

@@ src/pstfs_pkg.sv @@
// ------------------------------------------------------------------------
// pstfs_pkg
// Types, codes and control store of the piece span to file segment mapper.
// ------------------------------------------------------------------------
package pstfs_pkg;

  localparam int MAX_FILES = 16;
  localparam int SLOT_W    = $clog2(MAX_FILES);
  localparam int FILE_W    = 5;
  localparam int LEN_W     = 40;
  localparam int SPAN_W    = 25;
  localparam int PIDX_W    = 20;
  localparam int POFF_W    = 24;
  localparam int PLEN_W    = 25;
  localparam int PROD_W    = PIDX_W + PLEN_W;
  localparam int POS_W     = PROD_W + 1;
  localparam int CFG_W     = 25;

  localparam logic [PLEN_W-1:0] PIECE_LENGTH_RST = PLEN_W'(262144);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MAP  = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_PIECE_LENGTH = 1'b0,
    REG_FILE_COUNT   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    cmd_t              command;
    logic [3:0]        slot_index;
    logic [LEN_W-1:0]  file_length;
    logic [PIDX_W-1:0] piece_index;
    logic [POFF_W-1:0] piece_offset;
    logic [SPAN_W-1:0] span_length;
  } in_item_t;

  typedef struct packed {
    logic [FILE_W-1:0] target_file;
    logic [LEN_W-1:0]  start_position;
    logic [SPAN_W-1:0] segment_length;
    logic              last;
    logic              overrun;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WALK,
    ST_EMIT
  } step_t;

  typedef enum logic [1:0] {
    OP_TAKE,
    OP_MUL,
    OP_WALK,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    CND_MAP,
    CND_ALWAYS,
    CND_FOUND,
    CND_SPAN_END
  } cond_t;

  typedef struct packed {
    logic  in_rdy;
    op_t   op;
    cond_t cond;
    step_t target;
  } ctl_t;

  // control store: stay on the step until cond holds, then jump to target
  function automatic ctl_t ucode(step_t s);
    ctl_t c;
    case (s)
      ST_IDLE: c = '{in_rdy: 1'b1, op: OP_TAKE, cond: CND_MAP,      target: ST_MUL};
      ST_MUL:  c = '{in_rdy: 1'b0, op: OP_MUL,  cond: CND_ALWAYS,   target: ST_WALK};
      ST_WALK: c = '{in_rdy: 1'b0, op: OP_WALK, cond: CND_FOUND,    target: ST_EMIT};
      ST_EMIT: c = '{in_rdy: 1'b0, op: OP_EMIT, cond: CND_SPAN_END, target: ST_IDLE};
      default: c = '{in_rdy: 1'b0, op: OP_TAKE, cond: CND_ALWAYS,   target: ST_IDLE};
    endcase
    return c;
  endfunction

endpackage

@@ src/piece_span_to_file_segments_top.sv @@
// ------------------------------------------------------------------------
// piece_span_to_file_segments_top
// Maps a byte span of a piece onto per-file segments of a multi-file set.
// ------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry requests. A load request writes one
//   file length into the 16-entry table. A map request
//   yields one out_data segment per file touched, in file order, last set
//   on the final one, overrun set when the span runs past the loaded files.
//   A map with zero span_length yields nothing.
//   cfg_we/cfg_index/cfg_data write piece_length and file_count; write
//   only while idle.
//   Steps of a map: accept, multiply, a table walk past the skipped
//   files, then the emit of each segment in turn. The walk and emit loops
//   share the one table read port. Next request is taken once the last
//   segment is in the output register.
//   Reset: sequencer idle, output empty, piece_length 262144, file_count 0.
//   Table contents are undefined until loaded.
//   A stalled out_ready holds the output register and stops the sequencer at its emit step.
// ------------------------------------------------------------------------
module piece_span_to_file_segments_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pstfs_pkg::in_item_t          in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pstfs_pkg::out_item_t         out_data,
  input  logic                         cfg_we,
  input  pstfs_pkg::cfg_reg_t          cfg_index,
  input  logic [pstfs_pkg::CFG_W-1:0]  cfg_data
);
  import pstfs_pkg::*;

  logic [PLEN_W-1:0] pl_r;
  logic [FILE_W-1:0] fc_r;
  logic [LEN_W-1:0]  tbl_r [MAX_FILES];
  logic [PIDX_W-1:0] pidx_r;
  logic [POFF_W-1:0] poff_r;
  logic [POS_W-1:0]  pos_r;
  logic [SPAN_W-1:0] need_r;
  logic [FILE_W-1:0] idx_r;
  step_t             step_r, step_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;

  ctl_t              ctl;
  logic [FILE_W-1:0] fc_eff;
  logic [LEN_W-1:0]  cur_len;
  logic [LEN_W-1:0]  remain;
  logic [SPAN_W-1:0] seg;
  logic [SPAN_W-1:0] need_left;
  logic [PROD_W-1:0] prod;
  logic              past_end, found, seg_last, out_free;
  logic              in_fire, emit_fire, go;

  assign ctl       = ucode(step_r);
  assign fc_eff    = (fc_r > FILE_W'(MAX_FILES)) ? FILE_W'(MAX_FILES) : fc_r;
  assign past_end  = idx_r >= fc_eff;
  assign cur_len   = tbl_r[idx_r[SLOT_W-1:0]];
  assign found     = past_end || (pos_r < {{(POS_W-LEN_W){1'b0}}, cur_len});
  assign remain    = cur_len - pos_r[LEN_W-1:0];
  assign seg       = (remain < {{(LEN_W-SPAN_W){1'b0}}, need_r}) ?
                     remain[SPAN_W-1:0] : need_r;
  assign need_left = need_r - seg;
  assign seg_last  = past_end || (need_left == '0);
  assign prod      = pidx_r * pl_r;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = ctl.in_rdy;
  assign in_fire   = in_valid && ctl.in_rdy;
  assign emit_fire = (ctl.op == OP_EMIT) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    case (ctl.cond)
      CND_MAP:      go = in_fire && (in_data.command == CMD_MAP) &&
                         (in_data.span_length != '0);
      CND_ALWAYS:   go = 1'b1;
      CND_FOUND:    go = found;
      CND_SPAN_END: go = emit_fire && seg_last;
      default:      go = 1'b0;
    endcase
    step_nxt = go ? ctl.target : step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      out_valid_r <= 1'b0;
      pl_r        <= PIECE_LENGTH_RST;
      fc_r        <= '0;
    end else begin
      step_r <= step_nxt;
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PIECE_LENGTH: pl_r <= cfg_data[PLEN_W-1:0];
          REG_FILE_COUNT:   fc_r <= cfg_data[FILE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_TAKE: begin
        if (in_fire) begin
          if (in_data.command == CMD_LOAD) begin
            tbl_r[in_data.slot_index[SLOT_W-1:0]] <= in_data.file_length;
          end else begin
            pidx_r <= in_data.piece_index;
            poff_r <= in_data.piece_offset;
            need_r <= in_data.span_length;
          end
        end
      end
      OP_MUL: begin
        pos_r <= {1'b0, prod} + {{(POS_W-POFF_W){1'b0}}, poff_r};
        idx_r <= '0;
      end
      OP_WALK: begin
        if (!found) begin
          pos_r <= pos_r - {{(POS_W-LEN_W){1'b0}}, cur_len};
          idx_r <= idx_r + 1'b1;
        end
      end
      OP_EMIT: begin
        if (emit_fire) begin
          if (past_end) begin
            out_data_r <= '{target_file: FILE_W'(MAX_FILES),
                            start_position: pos_r[LEN_W-1:0],
                            segment_length: need_r,
                            last: 1'b1, overrun: 1'b1};
          end else begin
            out_data_r <= '{target_file: idx_r,
                            start_position: pos_r[LEN_W-1:0],
                            segment_length: seg,
                            last: seg_last, overrun: 1'b0};
          end
          pos_r  <= '0;
          idx_r  <= idx_r + 1'b1;
          need_r <= need_left;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ src/pstfs_checker.sv @@
// ------------------------------------------------------------------------
// pstfs_checker
// Port-level checks of the span mapper, bound to the top level.
// ------------------------------------------------------------------------
`include "piece_span_to_file_segments_top_macros.svh"

module pstfs_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input pstfs_pkg::out_item_t out_data
);
  import pstfs_pkg::*;

  `PSTFS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "out_data changed under stall")
  `PSTFS_ASSERT(a_ovr_tail, out_valid && out_data.overrun |-> out_data.last && (out_data.target_file == FILE_W'(MAX_FILES)), "overrun segment not final or wrong file")
  `PSTFS_ASSERT(a_file_range, out_valid && !out_data.overrun |-> out_data.target_file < FILE_W'(MAX_FILES), "segment file index out of range")
  `PSTFS_NEVER(a_busy_mid_span, out_valid && !out_data.last && in_ready, "request taken mid span")

endmodule

bind piece_span_to_file_segments_top pstfs_checker u_pstfs_checker (.*);

@@ dv/piece_span_to_file_segments_top_tb.sv @@
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// piece_span_to_file_segments_top_tb
// Self-checking bench for the piece span to file segment mapper.
// A short stimulus table probes reset values, field extremes, zero spans,
// zero-length files, spans that overrun the loaded files and an oversized
// file count. Random phases with changing piece length and file count
// follow, each with one of four mixes of sender gaps and receiver stalls.
// Each segment is checked field by field against a typed or predicted one.
// ------------------------------------------------------------------------
module piece_span_to_file_segments_top_tb;
  import pstfs_pkg::*;

  localparam int STUCK_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 400;
  localparam int PHASES       = 8;
  localparam int PHASE_REQS   = 52;

  typedef struct packed {
    logic              reconfig;
    logic [PLEN_W-1:0] plen;
    logic [4:0]        fcount;
    in_item_t          req;
    logic              typed;
    out_item_t         seg;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we    = 1'b0;
  cfg_reg_t  cfg_index = REG_PIECE_LENGTH;
  logic [CFG_W-1:0] cfg_data = '0;

  // tags the request on the bus: expected segment typed in by hand
  logic      row_typed = 1'b0;
  out_item_t row_seg   = '0;

  logic [LEN_W-1:0]  file_len_tbl [MAX_FILES];
  logic [PLEN_W-1:0] cur_piece_len  = PIECE_LENGTH_RST;
  logic [4:0]        cur_file_count = '0;
  out_item_t         expected_segments [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic long_hold_req  = 1'b0;
  logic long_hold_done = 1'b0;
  int   hold_left      = 0;

  int fail_count    = 0;
  int loads_seen    = 0;
  int maps_seen     = 0;
  int segs_checked  = 0;
  int overruns_seen = 0;

  piece_span_to_file_segments_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic out_item_t seg_of(input logic [FILE_W-1:0] file,
                                       input logic [LEN_W-1:0] start,
                                       input logic [SPAN_W-1:0] len,
                                       input logic last, input logic ovr);
    out_item_t s;
    s.target_file    = file;
    s.start_position = start;
    s.segment_length = len;
    s.last           = last;
    s.overrun        = ovr;
    return s;
  endfunction

  // load updates the table; map expands the span into file segments
  function automatic void predict_segments(input in_item_t req);
    logic [63:0] pos;
    logic [63:0] need;
    logic [63:0] remain;
    logic [63:0] seg_len;
    int fc;
    int idx;
    if (req.command == CMD_LOAD) begin
      file_len_tbl[req.slot_index] = req.file_length;
      return;
    end
    fc   = (cur_file_count > 5'(MAX_FILES)) ? MAX_FILES : int'(cur_file_count);
    pos  = 64'(req.piece_index) * 64'(cur_piece_len) + 64'(req.piece_offset);
    need = 64'(req.span_length);
    idx  = 0;
    while (idx < fc && pos >= 64'(file_len_tbl[idx])) begin
      pos = pos - 64'(file_len_tbl[idx]);
      idx++;
    end
    while (need != 0) begin
      if (idx >= fc) begin
        expected_segments.insert(expected_segments.size(),
                                 seg_of(FILE_W'(MAX_FILES), pos[LEN_W-1:0],
                                        need[SPAN_W-1:0], 1'b1, 1'b1));
        need = 0;
      end else begin
        remain  = 64'(file_len_tbl[idx]) - pos;
        seg_len = (remain < need) ? remain : need;
        need    = need - seg_len;
        expected_segments.insert(expected_segments.size(),
                                 seg_of(FILE_W'(idx), pos[LEN_W-1:0],
                                        seg_len[SPAN_W-1:0], need == 0, 1'b0));
        pos = 0;
        idx++;
      end
    end
  endfunction

  function automatic in_item_t load_of(input logic [3:0] slot,
                                       input logic [LEN_W-1:0] len);
    in_item_t r;
    r = '0;
    r.command     = CMD_LOAD;
    r.slot_index  = slot;
    r.file_length = len;
    return r;
  endfunction

  function automatic in_item_t map_of(input logic [PIDX_W-1:0] pidx,
                                      input logic [POFF_W-1:0] off,
                                      input logic [SPAN_W-1:0] span);
    in_item_t r;
    r = '0;
    r.command      = CMD_MAP;
    r.piece_index  = pidx;
    r.piece_offset = off;
    r.span_length  = span;
    return r;
  endfunction

  function automatic stim_row_t pred_row(input in_item_t req);
    stim_row_t row;
    row = '0;
    row.req = req;
    return row;
  endfunction

  function automatic stim_row_t typed_row(input in_item_t req, input out_item_t seg);
    stim_row_t row;
    row = pred_row(req);
    row.typed = 1'b1;
    row.seg   = seg;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [PLEN_W-1:0] plen,
                                        input logic [4:0] fc, input in_item_t req);
    stim_row_t row;
    row = pred_row(req);
    row.reconfig = 1'b1;
    row.plen     = plen;
    row.fcount   = fc;
    return row;
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    fail_count++;
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  // request and segment monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (in_data.command == CMD_LOAD) loads_seen++;
        else maps_seen++;
        if (row_typed) expected_segments.insert(expected_segments.size(), row_seg);
        else predict_segments(in_data);
      end
      if (out_valid && out_ready) begin
        segs_checked++;
        if (out_data.overrun) overruns_seen++;
        if (expected_segments.size() == 0) begin
          fail_count++;
          $display("%0t ns: segment with none expected, expected nothing, actual %h",
                   $time, out_data);
        end else begin
          want = expected_segments[0];
          expected_segments.delete(0);
          if (out_data.target_file !== want.target_file)
            note_mismatch("target_file", 64'(want.target_file), 64'(out_data.target_file));
          if (out_data.start_position !== want.start_position)
            note_mismatch("start_position", 64'(want.start_position),
                          64'(out_data.start_position));
          if (out_data.segment_length !== want.segment_length)
            note_mismatch("segment_length", 64'(want.segment_length),
                          64'(out_data.segment_length));
          if (out_data.last !== want.last)
            note_mismatch("last", 64'(want.last), 64'(out_data.last));
          if (out_data.overrun !== want.overrun)
            note_mismatch("overrun", 64'(want.overrun), 64'(out_data.overrun));
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold on request
  always @(posedge clk) begin
    if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left      <= LONG_HOLD;
      out_ready      <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck = 0;
      else stuck++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_request(input in_item_t req, input logic typed,
                              input out_item_t seg);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= req;
    row_typed <= typed;
    row_seg   <= seg;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [PLEN_W-1:0] plen, input logic [4:0] fc);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PIECE_LENGTH;
    cfg_data  <= CFG_W'(plen);
    @(posedge clk);
    cfg_index <= REG_FILE_COUNT;
    cfg_data  <= CFG_W'(fc);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_piece_len  = plen;
    cur_file_count = fc;
  endtask

  initial begin : stimulus
    stim_row_t         dir_rows [26];
    in_item_t          req;
    logic [PLEN_W-1:0] plen;
    logic [4:0]        fc;
    int                pick;

    foreach (file_len_tbl[i]) file_len_tbl[i] = '0;

    dir_rows = '{
      typed_row(map_of(0, 0, 1), seg_of(FILE_W'(MAX_FILES), 0, 1, 1'b1, 1'b1)),
      typed_row(map_of(1, 5, 100), seg_of(FILE_W'(MAX_FILES), 262149, 100, 1'b1, 1'b1)),
      pred_row(map_of(20'hFFFFF, 24'hFFFFFF, 25'h1000000)),
      pred_row(map_of(3, 7, 0)),
      pred_row(load_of(0, 100)),
      pred_row(load_of(1, 0)),
      pred_row(load_of(2, 50)),
      pred_row(load_of(3, 1)),
      pred_row(load_of(4, 0)),
      pred_row(load_of(5, 0)),
      pred_row(load_of(6, 7)),
      pred_row(load_of(7, 3)),
      pred_row(load_of(8, 0)),
      pred_row(load_of(9, 20)),
      pred_row(load_of(10, 1)),
      pred_row(load_of(11, 5)),
      pred_row(load_of(12, 0)),
      pred_row(load_of(13, 9)),
      pred_row(load_of(14, 40'hFF_FFFF_FFFF)),
      pred_row(load_of(15, 2)),
      cfg_row(1, 3, map_of(0, 0, 150)),
      typed_row(map_of(100, 0, 10), seg_of(2, 0, 10, 1'b1, 1'b0)),
      pred_row(map_of(140, 0, 20)),
      typed_row(map_of(200, 0, 5), seg_of(FILE_W'(MAX_FILES), 50, 5, 1'b1, 1'b1)),
      cfg_row(PLEN_W'(16777216), 31, map_of(0, 150, 25'h1FFFFFF)),
      pred_row(map_of(20'hFFFFF, 24'hFFFFFF, 25'h1000000))
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].reconfig) begin
        wait_drained();
        set_config(dir_rows[i].plen, dir_rows[i].fcount);
      end
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].seg);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case ($urandom_range(3))
        0:       plen = 1;
        1:       plen = PLEN_W'(16777216);
        2:       plen = PLEN_W'($urandom_range(1, 64));
        default: plen = PLEN_W'($urandom_range(1, 16777216));
      endcase
      if ($urandom_range(9) == 0) fc = 5'($urandom_range(17, 31));
      else fc = 5'($urandom_range(0, 16));
      if (ph == 0) begin
        plen = 1;
        fc   = 16;
      end else if (ph == 1) begin
        plen = PLEN_W'(16777216);
        fc   = 16;
      end
      set_config(plen, fc);
      case (ph % 4)
        0:       begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1:       begin tx_idle_pct = 47; rx_idle_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_idle_pct = 47; end
        default: begin tx_idle_pct = 24; rx_idle_pct = 24; end
      endcase
      // receiver goes quiet while the sender keeps pushing requests
      if (ph == 4) long_hold_req <= 1'b1;

      for (int n = 0; n < PHASE_REQS; n++) begin
        if (n == PHASE_REQS / 2) wait_drained();
        req.slot_index   = 4'($urandom);
        req.file_length  = {8'($urandom), 32'($urandom)};
        req.piece_index  = 20'($urandom);
        req.piece_offset = 24'($urandom);
        req.span_length  = 25'($urandom);
        pick = $urandom_range(99);
        if (pick < 20) begin
          req.command = CMD_LOAD;
          pick = $urandom_range(99);
          if (pick < 20)      req.file_length = '0;
          else if (pick < 70) req.file_length = LEN_W'($urandom_range(1, 64));
          else if (pick < 95) req.file_length = LEN_W'($urandom_range(65, 4096));
        end else begin
          req.command = CMD_MAP;
          pick = $urandom_range(99);
          if (pick < 60)      req.piece_index = '0;
          else if (pick < 92) req.piece_index = PIDX_W'($urandom_range(0, 3));
          pick = $urandom_range(99);
          if (pick < 85) req.piece_offset = POFF_W'($urandom_range(0, 600));
          pick = $urandom_range(99);
          if (pick < 5)       req.span_length = '0;
          else if (pick < 85) req.span_length = SPAN_W'($urandom_range(1, 400));
          else if (pick < 97) req.span_length = SPAN_W'($urandom_range(401, 16777216));
        end
        send_request(req, 1'b0, '0);
      end
    end

    wait_drained();
    $display("Covered %0d loads and %0d maps over %0d random phases of settings and idling,",
             loads_seen, maps_seen, PHASES);
    $display("with %0d segments checked, %0d of them past the loaded files.",
             segs_checked, overruns_seen);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/pstfs_pkg.sv
src/piece_span_to_file_segments_top.sv
src/pstfs_checker.sv
dv/piece_span_to_file_segments_top_tb.sv
